// ===== hw/rtl/mbg_pkg.sv =====
// Shared types and constants of the maze backtracker generator.
`timescale 1ns / 1ps

package mbg_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic OP_CARVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] DIR_LEFT = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDC,
    ST_RDU,
    ST_RDD,
    ST_EVAL,
    ST_DEC,
    ST_MOVE,
    ST_POP
  } state_t;

  typedef enum logic [1:0] {
    ROW_CUR,
    ROW_UP,
    ROW_DOWN
  } row_sel_t;

  typedef struct packed {
    logic     restart;
    logic     clear_row;
    logic     cfg_wr;
    logic     load_item;
    logic     rd_en;
    row_sel_t rd_row;
    logic     latch_c;
    logic     latch_u;
    logic     latch_d;
    logic     mark;
    logic     decide;
    logic     emit_move;
    logic     pop_load;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic done;
    logic finish_now;
    logic has_cand;
    logic stack_nonempty;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mbg_if.sv =====
// Handshake channel interfaces of the maze backtracker generator.
`timescale 1ns / 1ps

interface mbg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] random_value;

  modport source (output valid, output operation, output random_value, input ready);
  modport sink (input valid, input operation, input random_value, output ready);
endinterface

interface mbg_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] clear_x;
  logic [5:0] clear_y;
  logic       last;
  logic       finished;

  modport source (output valid, output clear_x, output clear_y, output last,
                  output finished, input ready);
  modport sink (input valid, input clear_x, input clear_y, input last,
                input finished, output ready);
endinterface

interface mbg_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mbg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/mbg_ctl.sv =====
// Controller state machine of the maze backtracker generator.
`timescale 1ns / 1ps

module mbg_ctl import mbg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_operation,
  output logic in_ready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  sts_t stat,
  output ctl_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          state_nxt = ST_CLEAR;
        end else if (in_valid) begin
          if (in_operation == OP_RESTART) begin
            state_nxt = ST_CLEAR;
          end else if (!stat.done) begin
            state_nxt = ST_RDC;
          end
        end
      end
      ST_RDC: state_nxt = ST_RDU;
      ST_RDU: state_nxt = ST_RDD;
      ST_RDD: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_DEC;
      ST_DEC: begin
        if (stat.out_free) begin
          if (stat.finish_now) begin
            state_nxt = ST_IDLE;
          end else if (stat.has_cand) begin
            state_nxt = ST_MOVE;
          end else if (stat.stack_nonempty) begin
            state_nxt = ST_POP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MOVE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_row = ROW_CUR;
    in_ready = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_row = 1'b1;
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          cmd.restart = 1'b1;
        end else if (in_valid) begin
          if (in_operation == OP_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            cmd.load_item = 1'b1;
          end
        end
      end
      ST_RDC: begin
        cmd.rd_en = 1'b1;
        cmd.rd_row = ROW_CUR;
      end
      ST_RDU: begin
        cmd.rd_en = 1'b1;
        cmd.rd_row = ROW_UP;
        cmd.latch_c = 1'b1;
      end
      ST_RDD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_row = ROW_DOWN;
        cmd.latch_u = 1'b1;
      end
      ST_EVAL: begin
        cmd.latch_d = 1'b1;
        cmd.mark = 1'b1;
      end
      ST_DEC: cmd.decide = stat.out_free;
      ST_MOVE: cmd.emit_move = stat.out_free;
      ST_POP: cmd.pop_load = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/mbg_datapath.sv =====
// Datapath of the maze backtracker generator: grid state, memories and result register.
`timescale 1ns / 1ps

module mbg_datapath import mbg_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  cmd,
  output sts_t                  stat,
  input  logic [7:0]            in_random_value,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_clear_x,
  output logic [5:0]            out_clear_y,
  output logic                  out_last,
  output logic                  out_finished
);

  localparam int HALF = MAX_SIDE / 2;
  localparam int CB = $clog2(HALF);
  localparam int SIDE_W = CB + 1;
  localparam int CELLS = HALF * HALF;
  localparam int SA = $clog2(CELLS);
  localparam int SD_W = $clog2(CELLS + 1);
  localparam int CL_W = 2 * SIDE_W;
  localparam int OW = CB + 7;

  function automatic logic [SIDE_W-1:0] side_cells(input logic [CFG_DATA_W-1:0] v);
    logic [8:0] s;
    s = {2'b00, v};
    if (s < 9'd2) begin
      s = 9'd2;
    end else if (s > 9'(MAX_SIDE)) begin
      s = 9'(MAX_SIDE);
    end
    return SIDE_W'(s >> 1);
  endfunction

  function automatic logic [1:0] pick_index(input logic [7:0] r, input logic [2:0] n);
    logic [3:0] s;
    logic [2:0] t;
    logic [1:0] p;
    s = {2'b00, r[1:0]} + {2'b00, r[3:2]} + {2'b00, r[5:4]} + {2'b00, r[7:6]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    unique case (n)
      3'd2: p = {1'b0, r[0]};
      3'd3: p = t[1:0];
      3'd4: p = r[1:0];
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  logic [CFG_DATA_W-1:0] grid_w_r, grid_w_nxt;
  logic [CFG_DATA_W-1:0] grid_h_r, grid_h_nxt;
  logic [CB-1:0]         cx_r, cx_nxt;
  logic [CB-1:0]         cy_r, cy_nxt;
  logic [CB-1:0]         nx_r, nx_nxt;
  logic [CB-1:0]         ny_r, ny_nxt;
  logic [SD_W-1:0]       depth_r, depth_nxt;
  logic [CL_W-1:0]       cells_left_r, cells_left_nxt;
  logic                  done_r, done_nxt;
  logic [CB-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [7:0]            rnd_r, rnd_nxt;
  logic [HALF-1:0]       row_c_r, row_c_nxt;
  logic [HALF-1:0]       row_u_r, row_u_nxt;
  logic [HALF-1:0]       row_d_r, row_d_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [5:0]            out_x_r, out_x_nxt;
  logic [5:0]            out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_fin_r, out_fin_nxt;

  logic [SIDE_W-1:0] cw;
  logic [SIDE_W-1:0] ch;
  logic [CL_W-1:0]   cells_total;
  logic [CB-1:0]     cx_m1;
  logic [CB-1:0]     cx_p1;
  logic [CB-1:0]     cy_m1;
  logic [CB-1:0]     cy_p1;
  logic [3:0]        cand;
  logic [2:0]        cand_n;
  logic [1:0]        pick;
  logic [1:0]        dir;
  logic [CB-1:0]     sel_x;
  logic [CB-1:0]     sel_y;
  logic [OW-1:0]     here_x;
  logic [OW-1:0]     here_y;
  logic [OW-1:0]     pass_x;
  logic [OW-1:0]     pass_y;
  logic              out_free;
  logic              push_go;
  logic              pop_go;

  logic              vis_wr_en;
  logic [CB-1:0]     vis_wr_addr;
  logic [HALF-1:0]   vis_wr_data;
  logic [CB-1:0]     vis_rd_addr;
  logic [HALF-1:0]   vis_rd_data;
  logic [2*CB-1:0]   stk_rd_data;

  assign cw = side_cells(grid_w_r);
  assign ch = side_cells(grid_h_r);
  assign cells_total = CL_W'(cw) * CL_W'(ch);

  assign cx_m1 = cx_r - CB'(1);
  assign cx_p1 = cx_r + CB'(1);
  assign cy_m1 = cy_r - CB'(1);
  assign cy_p1 = cy_r + CB'(1);

  assign cand[0] = (cx_r != '0) && !row_c_r[cx_m1];
  assign cand[1] = (cy_r != '0) && !row_u_r[cx_r];
  assign cand[2] = ((SIDE_W'(cy_r) + SIDE_W'(1)) < ch) && !row_d_r[cx_r];
  assign cand[3] = ((SIDE_W'(cx_r) + SIDE_W'(1)) < cw) && !row_c_r[cx_p1];
  assign cand_n = 3'($countones(cand));
  assign pick = pick_index(rnd_r, cand_n);

  always_comb begin
    logic [2:0] seen;
    seen = '0;
    dir = DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, pick}) begin
          dir = 2'(i);
        end
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    sel_x = cx_r;
    sel_y = cy_r;
    unique case (dir)
      DIR_LEFT: sel_x = cx_m1;
      DIR_UP: sel_y = cy_m1;
      DIR_DOWN: sel_y = cy_p1;
      DIR_RIGHT: sel_x = cx_p1;
      default: sel_x = cx_r;
    endcase
  end

  assign here_x = OW'(cx_r) << 1;
  assign here_y = OW'(cy_r) << 1;
  assign pass_x = OW'(cx_r) + OW'(nx_r);
  assign pass_y = OW'(cy_r) + OW'(ny_r);

  assign out_free = !out_valid_r || out_ready;
  assign push_go = cmd.decide && (cells_left_r != '0) && (cand_n != '0)
                   && (depth_r < SD_W'(CELLS));
  assign pop_go = cmd.decide && (cells_left_r != '0) && (cand_n == '0) && (depth_r != '0);

  always_comb begin
    grid_w_nxt = grid_w_r;
    grid_h_nxt = grid_h_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    nx_nxt = nx_r;
    ny_nxt = ny_r;
    depth_nxt = depth_r;
    cells_left_nxt = cells_left_r;
    done_nxt = done_r;
    clr_cnt_nxt = clr_cnt_r;
    rnd_nxt = rnd_r;
    row_c_nxt = row_c_r;
    row_u_nxt = row_u_r;
    row_d_nxt = row_d_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    out_last_nxt = out_last_r;
    out_fin_nxt = out_fin_r;

    if (cmd.cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: grid_w_nxt = cfg_data;
        REG_GRID_HEIGHT: grid_h_nxt = cfg_data;
        default: grid_w_nxt = grid_w_r;
      endcase
    end
    if (cmd.restart) begin
      cx_nxt = '0;
      cy_nxt = '0;
      depth_nxt = '0;
      done_nxt = 1'b0;
      clr_cnt_nxt = '0;
    end
    if (cmd.clear_row) begin
      clr_cnt_nxt = clr_cnt_r + CB'(1);
      cells_left_nxt = cells_total;
    end
    if (cmd.load_item) begin
      rnd_nxt = in_random_value;
    end
    if (cmd.latch_c) begin
      row_c_nxt = vis_rd_data;
    end
    if (cmd.latch_u) begin
      row_u_nxt = vis_rd_data;
    end
    if (cmd.latch_d) begin
      row_d_nxt = vis_rd_data;
    end
    if (cmd.mark && !row_c_r[cx_r] && (cells_left_r != '0)) begin
      cells_left_nxt = cells_left_r - CL_W'(1);
    end
    if (cmd.decide) begin
      out_valid_nxt = 1'b1;
      out_x_nxt = here_x[5:0];
      out_y_nxt = here_y[5:0];
      if (cells_left_r == '0) begin
        done_nxt = 1'b1;
        out_last_nxt = 1'b1;
        out_fin_nxt = 1'b1;
      end else if (cand_n != '0) begin
        out_last_nxt = 1'b0;
        out_fin_nxt = 1'b0;
        nx_nxt = sel_x;
        ny_nxt = sel_y;
        if (push_go) begin
          depth_nxt = depth_r + SD_W'(1);
        end
      end else begin
        out_last_nxt = 1'b1;
        out_fin_nxt = 1'b0;
        if (pop_go) begin
          depth_nxt = depth_r - SD_W'(1);
        end
      end
    end
    if (cmd.emit_move) begin
      out_valid_nxt = 1'b1;
      out_x_nxt = pass_x[5:0];
      out_y_nxt = pass_y[5:0];
      out_last_nxt = 1'b1;
      out_fin_nxt = 1'b0;
      cx_nxt = nx_r;
      cy_nxt = ny_r;
    end
    if (cmd.pop_load) begin
      cy_nxt = stk_rd_data[2*CB-1:CB];
      cx_nxt = stk_rd_data[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= 7'd32;
      grid_h_r <= 7'd32;
      cx_r <= '0;
      cy_r <= '0;
      depth_r <= '0;
      cells_left_r <= '0;
      done_r <= 1'b0;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      grid_w_r <= grid_w_nxt;
      grid_h_r <= grid_h_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      depth_r <= depth_nxt;
      cells_left_r <= cells_left_nxt;
      done_r <= done_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    rnd_r <= rnd_nxt;
    row_c_r <= row_c_nxt;
    row_u_r <= row_u_nxt;
    row_d_r <= row_d_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_last_r <= out_last_nxt;
    out_fin_r <= out_fin_nxt;
  end

  always_comb begin
    unique case (cmd.rd_row)
      ROW_CUR: vis_rd_addr = cy_r;
      ROW_UP: vis_rd_addr = cy_m1;
      ROW_DOWN: vis_rd_addr = cy_p1;
      default: vis_rd_addr = cy_r;
    endcase
  end

  assign vis_wr_en = cmd.clear_row || cmd.mark;
  assign vis_wr_addr = cmd.clear_row ? clr_cnt_r : cy_r;
  assign vis_wr_data = cmd.clear_row ? '0 : (row_c_r | (HALF'(1) << cx_r));

  mbg_ram #(
    .WIDTH (HALF),
    .DEPTH (HALF)
  ) u_visited (
    .clk     (clk),
    .wr_en   (vis_wr_en),
    .wr_addr (vis_wr_addr),
    .wr_data (vis_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (vis_rd_addr),
    .rd_data (vis_rd_data)
  );

  mbg_ram #(
    .WIDTH (2 * CB),
    .DEPTH (CELLS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_go),
    .wr_addr (SA'(depth_r)),
    .wr_data ({cy_r, cx_r}),
    .rd_en   (pop_go),
    .rd_addr (SA'(depth_r - SD_W'(1))),
    .rd_data (stk_rd_data)
  );

  assign stat.clr_last = (clr_cnt_r == CB'(HALF - 1));
  assign stat.done = done_r;
  assign stat.finish_now = (cells_left_r == '0);
  assign stat.has_cand = (cand_n != '0);
  assign stat.stack_nonempty = (depth_r != '0);
  assign stat.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_clear_x = out_x_r;
  assign out_clear_y = out_y_r;
  assign out_last = out_last_r;
  assign out_finished = out_fin_r;

endmodule

// ===== hw/rtl/maze_backtracker_generator.sv =====
// Top level of the maze backtracker generator: controller, datapath and channel wiring.
//
//   Channel | Direction | Payload                                | Accepted when
//   in_ch   | input     | operation, random_value                | valid && ready
//   out_ch  | output    | clear_x, clear_y, last, finished       | valid && ready
//   cfg_ch  | input     | index (0 width, 1 height), data        | valid && ready
//
// A carve item that moves or backtracks passes the accepting idle state, three row reads of the
// visited memory, the update write, the decision with the stack access and then the second result
// or the stack load. A completing or stuck item ends after the decision,
// and a carve item after completion is taken in the idle state alone.
// A restart item or a register write starts a clearing pass over the MAX_SIDE/2 visited rows,
// one visited row per cycle; reset runs the same pass before the first item is taken.
// A result waits in the output register while the next item is taken; a step stalls only
// when it must emit and that register is still full.
`timescale 1ns / 1ps

module maze_backtracker_generator import mbg_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  mbg_in_if.sink    in_ch,
  mbg_out_if.source out_ch,
  mbg_cfg_if.sink   cfg_ch
);

  ctl_t cmd;
  sts_t stat;

  mbg_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  mbg_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_random_value (in_ch.random_value),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_clear_x     (out_ch.clear_x),
    .out_clear_y     (out_ch.clear_y),
    .out_last        (out_ch.last),
    .out_finished    (out_ch.finished)
  );

endmodule

// ===== verif/tb_maze_backtracker_generator.sv =====
// Self-checking testbench of the maze backtracker generator with its own carving predictor.
`timescale 1ns / 1ps

module tb_maze_backtracker_generator import mbg_pkg::*;;

  localparam int MAX_SIDE = 64;
  localparam int HALF_SIDE = MAX_SIDE / 2;
  localparam int CELLS = HALF_SIDE * HALF_SIDE;
  localparam int SETTLE_CYCLES = 2 * HALF_SIDE + 16;
  // The limit must cover the slowest run: over 550 items with gaps, stalls and clearing passes.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [5:0] x;
    logic [5:0] y;
    logic       last;
    logic       finished;
  } square_t;

  class maze_walk;
    bit         seen [CELLS];
    int         trail [CELLS];
    int         here;
    int         trail_depth;
    int         cells_open;
    bit         complete;
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    square_t    expected [$];
    int         errors;

    function new();
      width_reg = 7'd32;
      height_reg = 7'd32;
      errors = 0;
      restart_walk();
    endfunction

    function int cells_on(logic [6:0] side);
      int s;
      s = side;
      if (s < 2) s = 2;
      if (s > MAX_SIDE) s = MAX_SIDE;
      return s / 2;
    endfunction

    function void restart_walk();
      foreach (seen[i]) seen[i] = 1'b0;
      here = 0;
      trail_depth = 0;
      cells_open = cells_on(width_reg) * cells_on(height_reg);
      complete = 1'b0;
    endfunction

    function void set_side(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GRID_WIDTH) width_reg = val;
      else height_reg = val;
      restart_walk();
    endfunction

    function void expect_square(int x, int y, bit last, bit fin);
      square_t s;
      s.x = x[5:0];
      s.y = y[5:0];
      s.last = last;
      s.finished = fin;
      expected.insert(expected.size(), s);
    endfunction

    // Returns the number of result items that this item causes.
    function int take_item(logic op, logic [7:0] pick_value);
      int cw, ch, cx, cy, n, nxt;
      int cand [4];
      if (op == OP_RESTART) begin
        restart_walk();
        return 0;
      end
      if (complete) return 0;
      cw = cells_on(width_reg);
      ch = cells_on(height_reg);
      cx = here % HALF_SIDE;
      cy = here / HALF_SIDE;
      if (!seen[here]) begin
        seen[here] = 1'b1;
        if (cells_open > 0) cells_open--;
      end
      if (cells_open == 0) begin
        complete = 1'b1;
        expect_square(2 * cx, 2 * cy, 1'b1, 1'b1);
        return 1;
      end
      n = 0;
      if (cx >= 1 && !seen[here - 1]) begin
        cand[n] = here - 1;
        n++;
      end
      if (cy >= 1 && !seen[here - HALF_SIDE]) begin
        cand[n] = here - HALF_SIDE;
        n++;
      end
      if (cy + 1 < ch && !seen[here + HALF_SIDE]) begin
        cand[n] = here + HALF_SIDE;
        n++;
      end
      if (cx + 1 < cw && !seen[here + 1]) begin
        cand[n] = here + 1;
        n++;
      end
      if (n > 0) begin
        nxt = cand[pick_value % n];
        if (trail_depth < CELLS) begin
          trail[trail_depth] = here;
          trail_depth++;
        end
        expect_square(2 * cx, 2 * cy, 1'b0, 1'b0);
        expect_square(cx + nxt % HALF_SIDE, cy + nxt / HALF_SIDE, 1'b1, 1'b0);
        here = nxt;
        return 2;
      end
      expect_square(2 * cx, 2 * cy, 1'b1, 1'b0);
      if (trail_depth > 0) begin
        trail_depth--;
        here = trail[trail_depth];
      end
      return 1;
    endfunction

    function void check_square(logic [5:0] x, logic [5:0] y, logic last, logic fin);
      square_t want;
      if (expected.size() == 0) begin
        $error("unexpected result item x=%0d y=%0d last=%0d finished=%0d", x, y, last, fin);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (x !== want.x) begin
        $error("clear_x expected %0d actual %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("clear_y expected %0d actual %0d", want.y, y);
        errors++;
      end
      if (last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, last);
        errors++;
      end
      if (fin !== want.finished) begin
        $error("finished expected %0d actual %0d", want.finished, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mbg_in_if  in_ch ();
  mbg_out_if out_ch ();
  mbg_cfg_if cfg_ch ();

  maze_backtracker_generator #(.MAX_SIDE(MAX_SIDE)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  maze_walk    walk = new();
  int          burst_left = 0;
  int          carved = 0;
  int          squares_seen = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_maze_backtracker_generator: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      walk.check_square(out_ch.clear_x, out_ch.clear_y, out_ch.last, out_ch.finished);
      squares_seen++;
    end
  end

  initial begin : result_side
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && squares_seen >= 150) begin
        held = 1'b1;
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 0);
          2: out_ch.ready <= ($urandom_range(0, 6) != 0);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] pick_value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.random_value <= pick_value;
    do @(posedge clk); while (!in_ch.ready);
    void'(walk.take_item(op, pick_value));
    carved++;
  endtask

  task automatic end_burst();
    @(negedge clk) in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic settle();
    while (walk.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    walk.set_side(idx, val);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    end_burst();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
  endtask

  initial begin : stimulus
    int phase;
    int len;
    logic [6:0] w;
    logic [6:0] h;
    logic op;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_CARVE;
    in_ch.random_value = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GRID_WIDTH;
    cfg_ch.data = 7'd0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Default 32 by 32 grid, then a single cell grid with the sides saturating low, then a 5 by 4 grid.
    send_item(OP_CARVE, 8'h00);
    send_item(OP_CARVE, 8'hFF);
    send_item(OP_CARVE, 8'h55);
    send_item(OP_CARVE, 8'hAA);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_CARVE, 8'h01);
    send_item(OP_CARVE, 8'h02);
    set_grid(7'd1, 7'd0);
    send_item(OP_CARVE, 8'h00);
    send_item(OP_CARVE, 8'hFF);
    send_item(OP_RESTART, 8'h00);
    send_item(OP_CARVE, 8'h80);
    set_grid(7'd5, 7'd4);
    repeat (6) send_item(OP_CARVE, 8'($urandom_range(0, 255)));

    carved = 0;
    phase = 0;
    while (carved < 550) begin
      case (phase)
        0: begin
          w = 7'd127;
          h = 7'd3;
        end
        1: begin
          w = 7'd1;
          h = 7'd64;
        end
        2: begin
          w = 7'd64;
          h = 7'd64;
        end
        3: begin
          w = 7'd0;
          h = 7'd0;
        end
        default: begin
          w = 7'($urandom_range(2, 14));
          h = 7'($urandom_range(2, 14));
          if ($urandom_range(0, 5) == 0) w = 7'($urandom_range(65, 127));
          if ($urandom_range(0, 5) == 0) h = 7'($urandom_range(65, 127));
        end
      endcase
      len = (phase < 2) ? 75 : $urandom_range(25, 60);
      set_grid(w, h);
      repeat (len) begin
        if (walk.complete) op = ($urandom_range(0, 1) == 0) ? OP_RESTART : OP_CARVE;
        else op = ($urandom_range(0, 29) == 0) ? OP_RESTART : OP_CARVE;
        send_item(op, 8'($urandom_range(0, 255)));
      end
      phase++;
    end

    end_burst();
    settle();
    if (walk.errors == 0) $display("tb_maze_backtracker_generator: done, clean");
    else $display("tb_maze_backtracker_generator: done, errors");
    $finish;
  end

endmodule

// ===== maze_backtracker_generator.f =====
hw/rtl/mbg_pkg.sv
hw/rtl/mbg_if.sv
hw/rtl/mbg_ram.sv
hw/rtl/mbg_ctl.sv
hw/rtl/mbg_datapath.sv
hw/rtl/maze_backtracker_generator.sv
verif/tb_maze_backtracker_generator.sv
